// ===== src/haptic_frame_check_and_unpack_assert.svh =====
// Assertion macros used by the checker file hfcu_checker.sv.
`ifndef HAPTIC_FRAME_CHECK_AND_UNPACK_ASSERT_SVH
`define HAPTIC_FRAME_CHECK_AND_UNPACK_ASSERT_SVH

// Same-cycle implication, disabled while rst is high.
`define HFCU_ASSERT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");

// Next-cycle implication, disabled while rst is high.
`define HFCU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

// ===== src/hfcu_pkg.sv =====
package hfcu_pkg;

   localparam int FRAME_BYTES   = 12;
   localparam int MOTORS        = 8;
   localparam int CAPTURE_DEPTH = FRAME_BYTES - 2;
   localparam int STOP_BIT      = 0;
   localparam logic [7:0] COUNT_MAX  = 8'hFF;
   localparam logic [7:0] LAST_COUNT = 8'(FRAME_BYTES - 1);

   // CSR word index decoded from paddr[2]
   localparam logic CSR_HEADER_IDX = 1'b0;

   typedef enum logic [1:0] {
      STATUS_OK           = 2'd0,
      STATUS_BAD_LENGTH   = 2'd1,
      STATUS_BAD_HEADER   = 2'd2,
      STATUS_BAD_CHECKSUM = 2'd3
   } status_type;

   typedef struct packed {
      logic [7:0]  byte_value;
      logic        last_byte;
      logic [31:0] arrival_time;
   } req_beat_type;

   typedef struct packed {
      status_type                  status;
      logic [7:0]                  sequence_res;
      logic [MOTORS-1:0][7:0]      motor;
      logic                        stop_request;
      logic [31:0]                 received_time;
   } result_type;

endpackage

// ===== src/hfcu_if.sv =====
interface hfcu_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  byte_value;
   logic        last_byte;
   logic [31:0] arrival_time;

   modport source (output valid, output byte_value, output last_byte, output arrival_time,
                   input ready);
   modport sink   (input valid, input byte_value, input last_byte, input arrival_time,
                   output ready);
endinterface

interface hfcu_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [7:0]  sequence_res;
   logic [7:0]  motor_0;
   logic [7:0]  motor_1;
   logic [7:0]  motor_2;
   logic [7:0]  motor_3;
   logic [7:0]  motor_4;
   logic [7:0]  motor_5;
   logic [7:0]  motor_6;
   logic [7:0]  motor_7;
   logic        stop_request;
   logic [31:0] received_time;

   modport source (output valid, output status, output sequence_res,
                   output motor_0, output motor_1, output motor_2, output motor_3,
                   output motor_4, output motor_5, output motor_6, output motor_7,
                   output stop_request, output received_time, input ready);
   modport sink   (input valid, input status, input sequence_res,
                   input motor_0, input motor_1, input motor_2, input motor_3,
                   input motor_4, input motor_5, input motor_6, input motor_7,
                   input stop_request, input received_time, output ready);
endinterface

// ===== src/hfcu_frame_acc.sv =====
module hfcu_frame_acc
   import hfcu_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         take,
   input  req_beat_type beat,
   input  logic [7:0]   header_value,
   output result_type   result
);

   logic [7:0] byte_count_ff, byte_count_in;
   logic [7:0] xor_sum_ff, xor_sum_in;
   logic       header_ok_ff, header_ok_in;
   logic [CAPTURE_DEPTH-1:0][7:0] capture_ff, capture_in;

   always_comb begin
      capture_in = capture_ff;
      for (int i = 0; i < CAPTURE_DEPTH; i++) begin
         if (take && byte_count_ff == 8'(i + 1)) begin
            capture_in[i] = beat.byte_value;
         end
      end
   end

   always_comb begin
      byte_count_in = byte_count_ff;
      xor_sum_in    = xor_sum_ff;
      header_ok_in  = header_ok_ff;
      if (take) begin
         if (beat.last_byte) begin
            // close the frame, next beat starts a new one
            byte_count_in = '0;
            xor_sum_in    = '0;
            header_ok_in  = 1'b0;
         end else begin
            xor_sum_in = xor_sum_ff ^ beat.byte_value;
            if (byte_count_ff == '0) begin
               header_ok_in = (beat.byte_value == header_value);
            end
            if (byte_count_ff != COUNT_MAX) begin
               byte_count_in = byte_count_ff + 8'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= '0;
         xor_sum_ff    <= '0;
         header_ok_ff  <= 1'b0;
      end else begin
         byte_count_ff <= byte_count_in;
         xor_sum_ff    <= xor_sum_in;
         header_ok_ff  <= header_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      capture_ff <= capture_in;
   end

   // Result for a closing beat; length is checked first, so the header flag
   // only matters once a full frame has been counted.
   always_comb begin
      result = '0;
      if (byte_count_ff != LAST_COUNT) begin
         result.status = STATUS_BAD_LENGTH;
      end else if (!header_ok_ff) begin
         result.status = STATUS_BAD_HEADER;
      end else if (xor_sum_ff != beat.byte_value) begin
         result.status = STATUS_BAD_CHECKSUM;
      end else begin
         result.status = STATUS_OK;
      end
      if (result.status == STATUS_OK) begin
         result.sequence_res = capture_ff[0];
         for (int m = 0; m < MOTORS; m++) begin
            result.motor[m] = capture_ff[m + 1];
         end
         result.stop_request = capture_ff[MOTORS + 1][STOP_BIT];
      end
      result.received_time = beat.arrival_time;
   end

endmodule

// ===== src/haptic_frame_check_and_unpack.sv =====
// Frame checker and unpacker for fixed-length haptic command frames.
// req_ch carries one frame byte per beat (byte_value, last_byte, arrival_time).
// rsp_ch carries one result per frame: status, sequence byte, eight motor
// intensities, stop flag and the timestamp of the last byte. Non-ok frames
// give zero payload fields but still report status and received_time.
// The APB-style CSR port holds header_value at address 0; writes land in the
// access phase, pready is tied high, reads return the register.
// A closing byte's result is registered and on rsp_ch in the cycle after its beat.
// Throughput: one byte per cycle while req_ch.ready is high; the per-byte work
// is a count update, one XOR and one compare ahead of the result register.
// When the receiver stalls, the result register holds its beat and req_ch
// keeps taking bytes as long as the held result is taken in the same cycle;
// otherwise req_ch.ready drops until rsp_ch.ready returns.
// Reset (synchronous, active high) clears the byte count, XOR, header flag,
// the result valid and header_value; the next byte starts a new frame.
module haptic_frame_check_and_unpack
   import hfcu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   hfcu_req_if.sink    req_ch,
   hfcu_rsp_if.source  rsp_ch,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic         header_sel, header_write;
   logic [7:0]   header_value_ff, header_value_in;
   logic         rsp_valid_ff, rsp_valid_in;
   result_type   rsp_data_ff, rsp_data_in;
   result_type   frame_result;
   req_beat_type req_beat;
   logic         req_take;
   logic         csr_write;

   // CSR: single header register, writes to any other word are dropped
   assign pready       = 1'b1;
   assign csr_write    = psel && penable && pwrite && pready;
   assign header_sel   = (paddr[2] == CSR_HEADER_IDX);
   assign header_write = header_sel && csr_write;

   always_comb begin
      header_value_in = header_value_ff;
      if (header_write) begin
         header_value_in = pwdata[7:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (header_sel) begin
         prdata = {24'd0, header_value_ff};
      end
   end

   // Input side: take a byte whenever the result slot is free or drains now
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign req_take     = req_ch.valid && req_ch.ready;

   assign req_beat.byte_value   = req_ch.byte_value;
   assign req_beat.last_byte    = req_ch.last_byte;
   assign req_beat.arrival_time = req_ch.arrival_time;

   hfcu_frame_acc u_frame_acc (
      .clock        (clock),
      .reset        (reset),
      .take         (req_take),
      .beat         (req_beat),
      .header_value (header_value_ff),
      .result       (frame_result)
   );

   // Result register: load on a closing byte, drop once taken, else hold
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (req_take && req_ch.last_byte) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = frame_result;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff    <= 1'b0;
         header_value_ff <= '0;
      end else begin
         rsp_valid_ff    <= rsp_valid_in;
         header_value_ff <= header_value_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.status        = rsp_data_ff.status;
   assign rsp_ch.sequence_res  = rsp_data_ff.sequence_res;
   assign rsp_ch.motor_0       = rsp_data_ff.motor[0];
   assign rsp_ch.motor_1       = rsp_data_ff.motor[1];
   assign rsp_ch.motor_2       = rsp_data_ff.motor[2];
   assign rsp_ch.motor_3       = rsp_data_ff.motor[3];
   assign rsp_ch.motor_4       = rsp_data_ff.motor[4];
   assign rsp_ch.motor_5       = rsp_data_ff.motor[5];
   assign rsp_ch.motor_6       = rsp_data_ff.motor[6];
   assign rsp_ch.motor_7       = rsp_data_ff.motor[7];
   assign rsp_ch.stop_request  = rsp_data_ff.stop_request;
   assign rsp_ch.received_time = rsp_data_ff.received_time;

endmodule

// ===== src/hfcu_checker.sv =====
`include "haptic_frame_check_and_unpack_assert.svh"

module hfcu_checker
   import hfcu_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_last,
   input logic [31:0] req_time,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic [7:0]  rsp_sequence,
   input logic [7:0]  rsp_motor_0,
   input logic [7:0]  rsp_motor_7,
   input logic        rsp_stop,
   input logic [31:0] rsp_time
);

   logic req_take;
   logic rsp_free;
   logic bad_frame;

   assign req_take  = req_valid && req_ready;
   assign rsp_free  = !rsp_valid || rsp_ready;
   assign bad_frame = rsp_status != STATUS_OK;

   `HFCU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_time))
   `HFCU_ASSERT_NEXT(a_last_gives_result, clock, reset, req_take && req_last, rsp_valid && rsp_time == $past(req_time))
   `HFCU_ASSERT_NEXT(a_mid_byte_no_result, clock, reset, req_take && !req_last && rsp_free, !rsp_valid)
   `HFCU_ASSERT(a_bad_frame_zero, clock, reset, rsp_valid && bad_frame, rsp_sequence == 8'd0 && rsp_motor_0 == 8'd0 && rsp_motor_7 == 8'd0 && !rsp_stop)
   `HFCU_ASSERT_NEXT(a_reset_clears, clock, 1'b0, reset, !rsp_valid)

endmodule

bind haptic_frame_check_and_unpack hfcu_checker u_hfcu_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .req_last     (req_ch.last_byte),
   .req_time     (req_ch.arrival_time),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .rsp_status   (rsp_ch.status),
   .rsp_sequence (rsp_ch.sequence_res),
   .rsp_motor_0  (rsp_ch.motor_0),
   .rsp_motor_7  (rsp_ch.motor_7),
   .rsp_stop     (rsp_ch.stop_request),
   .rsp_time     (rsp_ch.received_time)
);
